[rtl/rti_pkg.sv]
// shared constants and types for the ray triangle intersection pipeline
package rti_pkg;

	localparam int CB   = 21;           // coordinate width
	localparam int VW   = 3 * CB;       // packed vertex register width
	localparam int CS   = 3;            // floor shift applied to cross products
	localparam int EW   = CB + 1;       // edge and offset vector width
	localparam int MW   = 2 * EW;       // cross product term width
	localparam int PW   = MW + 1;       // cross product width
	localparam int QW   = PW - CS;      // floored cross product width
	localparam int PRD  = QW + EW;      // dot product term width
	localparam int DW   = PRD + 2;      // dot product width
	localparam int RPW  = CS + 1 + EW;  // remainder dot term width
	localparam int RDW  = RPW + 2;      // remainder dot width
	localparam int ZW   = DW + CS;      // exact dot width
	localparam int TW   = 32;           // distance width
	localparam int FRAC = 16;           // distance fraction bits
	localparam int BW   = FRAC + 1;     // barycentric width
	localparam int DIVW = DW - 1;       // divisor magnitude width
	localparam int RW   = DIVW + TW;    // divider residual width
	localparam int NQT  = TW;           // divider stages
	localparam int PTW  = TW + 1 + CB;  // distance times direction width
	localparam int PSW  = PTW - FRAC + 1; // hit point sum width
	localparam int CIW  = 3;            // register index width

	typedef enum logic [CIW-1:0] {
		REG_VERTEX_A = 3'd0,
		REG_VERTEX_B = 3'd1,
		REG_VERTEX_C = 3'd2,
		REG_T_MIN    = 3'd3,
		REG_T_MAX    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CB-1:0] ox;
		logic signed [CB-1:0] oy;
		logic signed [CB-1:0] oz;
		logic signed [CB-1:0] dx;
		logic signed [CB-1:0] dy;
		logic signed [CB-1:0] dz;
		logic [TW-1:0]        best;
	} side_t;

	typedef struct packed {
		logic par;
		logic par_hit;
		logic det_zero;
		logic tn_neg;
		logic far;
		logic tri_ok;
	} flags_t;

endpackage

[rtl/rti_front.sv]
// geometry stages: edges, cross products, dot products, sign normalisation and tests
module rti_front import rti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  side_t                side_i,
	input  logic [VW-1:0]        va,
	input  logic [VW-1:0]        vb,
	input  logic [VW-1:0]        vc,
	output logic                 vld_o,
	output side_t                side_o,
	output flags_t               flg_o,
	output logic signed [DW-1:0] det_o,
	output logic signed [DW-1:0] tn_o,
	output logic signed [DW-1:0] un_o,
	output logic signed [DW-1:0] vn_o
);

	logic signed [CB-1:0] vxa [3];
	logic signed [CB-1:0] vxb [3];
	logic signed [CB-1:0] vxc [3];
	logic signed [CB-1:0] o_in [3];
	logic signed [CB-1:0] d_in [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [CB-1:0] d_s1 [3];
	logic signed [MW-1:0] m1a_s2 [3], m1b_s2 [3], m2a_s2 [3], m2b_s2 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [CB-1:0] d_s2 [3];
	logic signed [PW-1:0] x1 [3], x2 [3];
	logic signed [QW-1:0] q1_s3 [3], q2_s3 [3];
	logic [CS-1:0]        r1_s3 [3], r2_s3 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [CB-1:0] d_s3 [3];
	logic signed [PRD-1:0] a1_s4 [3], b1_s4 [3], cu_s4 [3], cv_s4 [3];
	logic signed [RPW-1:0] ra_s4 [3], rb_s4 [3];

	logic signed [DW-1:0]  det_s5, tn_s5, un_s5, vn_s5;
	logic signed [RDW-1:0] rdet_s5, rtn_s5;
	logic signed [ZW-1:0]  zdet, ztn;

	logic signed [DW-1:0] det_s6, tn_s6, un_s6, vn_s6;
	logic par_s6, par_hit_s6, dz_s6;

	logic signed [DW+FRAC-1:0] tn_w, det_w;
	logic signed [DW:0]        uv_sum, det_x;

	logic signed [DW-1:0] det_s7, tn_s7, un_s7, vn_s7;
	flags_t flg_s7;

	assign o_in[0] = side_i.ox;
	assign o_in[1] = side_i.oy;
	assign o_in[2] = side_i.oz;
	assign d_in[0] = side_i.dx;
	assign d_in[1] = side_i.dy;
	assign d_in[2] = side_i.dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_axis
		localparam int A = (g + 1) % 3;
		localparam int B = (g + 2) % 3;

		assign vxa[g] = va[g*CB +: CB];
		assign vxb[g] = vb[g*CB +: CB];
		assign vxc[g] = vc[g*CB +: CB];

		assign x1[g] = PW'(m1a_s2[g]) - PW'(m1b_s2[g]);
		assign x2[g] = PW'(m2a_s2[g]) - PW'(m2b_s2[g]);

		always_ff @(posedge clk) begin
			if (en) begin
				// edges and origin offset
				e1_s1[g] <= EW'(vxb[g]) - EW'(vxa[g]);
				e2_s1[g] <= EW'(vxc[g]) - EW'(vxa[g]);
				s_s1[g]  <= EW'(o_in[g]) - EW'(vxa[g]);
				d_s1[g]  <= d_in[g];
				// cross product terms
				m1a_s2[g] <= MW'(d_s1[A]) * MW'(e2_s1[B]);
				m1b_s2[g] <= MW'(d_s1[B]) * MW'(e2_s1[A]);
				m2a_s2[g] <= MW'(s_s1[A]) * MW'(e1_s1[B]);
				m2b_s2[g] <= MW'(s_s1[B]) * MW'(e1_s1[A]);
				e1_s2[g]  <= e1_s1[g];
				e2_s2[g]  <= e2_s1[g];
				s_s2[g]   <= s_s1[g];
				d_s2[g]   <= d_s1[g];
				// floored cross products and their remainders
				q1_s3[g] <= QW'(x1[g] >>> CS);
				r1_s3[g] <= x1[g][CS-1:0];
				q2_s3[g] <= QW'(x2[g] >>> CS);
				r2_s3[g] <= x2[g][CS-1:0];
				e1_s3[g] <= e1_s2[g];
				e2_s3[g] <= e2_s2[g];
				s_s3[g]  <= s_s2[g];
				d_s3[g]  <= d_s2[g];
				// dot product terms
				a1_s4[g] <= PRD'(q1_s3[g]) * PRD'(e1_s3[g]);
				b1_s4[g] <= PRD'(q2_s3[g]) * PRD'(e2_s3[g]);
				cu_s4[g] <= PRD'(q1_s3[g]) * PRD'(s_s3[g]);
				cv_s4[g] <= PRD'(q2_s3[g]) * PRD'(d_s3[g]);
				ra_s4[g] <= RPW'($signed({1'b0, r1_s3[g]})) * RPW'(e1_s3[g]);
				rb_s4[g] <= RPW'($signed({1'b0, r2_s3[g]})) * RPW'(e2_s3[g]);
			end
		end
	end

	assign zdet = (ZW'(det_s5) <<< CS) + ZW'(rdet_s5);
	assign ztn  = (ZW'(tn_s5) <<< CS) + ZW'(rtn_s5);

	assign tn_w   = (DW+FRAC)'(tn_s6);
	assign det_w  = (DW+FRAC)'(det_s6) <<< FRAC;
	assign uv_sum = (DW+1)'(un_s6) + (DW+1)'(vn_s6);
	assign det_x  = (DW+1)'(det_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;

			det_s5  <= DW'(a1_s4[0]) + DW'(a1_s4[1]) + DW'(a1_s4[2]);
			tn_s5   <= DW'(b1_s4[0]) + DW'(b1_s4[1]) + DW'(b1_s4[2]);
			un_s5   <= DW'(cu_s4[0]) + DW'(cu_s4[1]) + DW'(cu_s4[2]);
			vn_s5   <= DW'(cv_s4[0]) + DW'(cv_s4[1]) + DW'(cv_s4[2]);
			rdet_s5 <= RDW'(ra_s4[0]) + RDW'(ra_s4[1]) + RDW'(ra_s4[2]);
			rtn_s5  <= RDW'(rb_s4[0]) + RDW'(rb_s4[1]) + RDW'(rb_s4[2]);

			// exact zero tests and sign normalisation
			par_s6     <= (zdet == '0);
			par_hit_s6 <= (ztn == '0);
			dz_s6      <= (det_s5 == '0);
			if (det_s5[DW-1]) begin
				det_s6 <= -det_s5;
				tn_s6  <= -tn_s5;
				un_s6  <= -un_s5;
				vn_s6  <= -vn_s5;
			end else begin
				det_s6 <= det_s5;
				tn_s6  <= tn_s5;
				un_s6  <= un_s5;
				vn_s6  <= vn_s5;
			end

			flg_s7.par      <= par_s6;
			flg_s7.par_hit  <= par_hit_s6;
			flg_s7.det_zero <= dz_s6;
			flg_s7.tn_neg   <= tn_s6[DW-1];
			flg_s7.far      <= (tn_w >= det_w);
			flg_s7.tri_ok   <= !un_s6[DW-1] && !vn_s6[DW-1] && (uv_sum <= det_x);
			det_s7 <= det_s6;
			tn_s7  <= tn_s6;
			un_s7  <= un_s6;
			vn_s7  <= vn_s6;
		end
	end

	assign vld_o  = vld_s7;
	assign side_o = side_s7;
	assign flg_o  = flg_s7;
	assign det_o  = det_s7;
	assign tn_o   = tn_s7;
	assign un_o   = un_s7;
	assign vn_o   = vn_s7;

endmodule

[rtl/rti_div.sv]
// pipelined restoring divider, one quotient bit per stage for t, and for u and v in the last BW stages
module rti_div import rti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  side_t                side_i,
	input  flags_t               flg_i,
	input  logic signed [DW-1:0] det_i,
	input  logic signed [DW-1:0] tn_i,
	input  logic signed [DW-1:0] un_i,
	input  logic signed [DW-1:0] vn_i,
	output logic                 vld_o,
	output side_t                side_o,
	output flags_t               flg_o,
	output logic [TW-1:0]        t_o,
	output logic                 inexact_o,
	output logic [BW-1:0]        u_o,
	output logic [BW-1:0]        v_o
);

	logic            vld_s  [NQT+1];
	side_t           side_s [NQT+1];
	flags_t          flg_s  [NQT+1];
	logic [DIVW-1:0] dd_s   [NQT+1];
	logic [RW-1:0]   rt_s   [NQT+1];
	logic [RW-1:0]   ru_s   [NQT+1];
	logic [RW-1:0]   rv_s   [NQT+1];
	logic [TW-1:0]   qt_s   [NQT+1];
	logic [BW-1:0]   qu_s   [NQT+1];
	logic [BW-1:0]   qv_s   [NQT+1];

	assign vld_s[0]  = vld_i;
	assign side_s[0] = side_i;
	assign flg_s[0]  = flg_i;
	assign dd_s[0]   = det_i[DIVW-1:0];
	assign rt_s[0]   = RW'({tn_i[DIVW-1:0], {FRAC{1'b0}}});
	assign ru_s[0]   = RW'({un_i[DIVW-1:0], {FRAC{1'b0}}});
	assign rv_s[0]   = RW'({vn_i[DIVW-1:0], {FRAC{1'b0}}});
	assign qt_s[0]   = '0;
	assign qu_s[0]   = '0;
	assign qv_s[0]   = '0;

	for (genvar g = 0; g < NQT; g++) begin : g_stage
		localparam int SH = NQT - 1 - g;

		logic [RW-1:0] dsh;
		logic          ge_t;

		assign dsh  = RW'(dd_s[g]) << SH;
		assign ge_t = (rt_s[g] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				flg_s[g+1]  <= flg_s[g];
				dd_s[g+1]   <= dd_s[g];
				rt_s[g+1]   <= ge_t ? rt_s[g] - dsh : rt_s[g];
				qt_s[g+1]   <= qt_s[g] | (TW'(ge_t) << SH);
			end
		end

		if (SH < BW) begin : g_bary
			logic ge_u, ge_v;

			assign ge_u = (ru_s[g] >= dsh);
			assign ge_v = (rv_s[g] >= dsh);

			always_ff @(posedge clk) begin
				if (en) begin
					ru_s[g+1] <= ge_u ? ru_s[g] - dsh : ru_s[g];
					rv_s[g+1] <= ge_v ? rv_s[g] - dsh : rv_s[g];
					qu_s[g+1] <= qu_s[g] | (BW'(ge_u) << SH);
					qv_s[g+1] <= qv_s[g] | (BW'(ge_v) << SH);
				end
			end
		end else begin : g_wait
			always_ff @(posedge clk) begin
				if (en) begin
					ru_s[g+1] <= ru_s[g];
					rv_s[g+1] <= rv_s[g];
					qu_s[g+1] <= qu_s[g];
					qv_s[g+1] <= qv_s[g];
				end
			end
		end
	end

	assign vld_o     = vld_s[NQT];
	assign side_o    = side_s[NQT];
	assign flg_o     = flg_s[NQT];
	assign t_o       = qt_s[NQT];
	assign inexact_o = (rt_s[NQT] != '0);
	assign u_o       = qu_s[NQT];
	assign v_o       = qv_s[NQT];

endmodule

[rtl/rti_back.sv]
// result stages: range test, hit decision, hit point with saturation, output register
module rti_back import rti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  side_t                side_i,
	input  flags_t               flg_i,
	input  logic [TW-1:0]        t_i,
	input  logic                 inexact_i,
	input  logic [BW-1:0]        u_i,
	input  logic [BW-1:0]        v_i,
	input  logic [TW-1:0]        t_min,
	input  logic [TW-1:0]        t_max,
	output logic                 vld_o,
	output logic                 hit,
	output logic                 closer,
	output logic [TW-1:0]        new_dist,
	output logic signed [CB-1:0] point_x,
	output logic signed [CB-1:0] point_y,
	output logic signed [CB-1:0] point_z,
	output logic [BW-1:0]        bary_u,
	output logic [BW-1:0]        bary_v
);

	localparam logic signed [PSW-1:0] PMAX = (PSW'(1) <<< (CB - 1)) - PSW'(1);
	localparam logic signed [PSW-1:0] PMIN = -(PSW'(1) <<< (CB - 1));

	logic signed [CB-1:0] d_in [3];
	logic signed [CB-1:0] o_in [3];
	logic range_ok, tri_hit;

	logic                  vld_s40, hit_s40, closer_s40;
	logic [TW-1:0]         t_s40, best_s40;
	logic [BW-1:0]         u_s40, v_s40;
	logic signed [PTW-1:0] pt_s40 [3];
	logic signed [CB-1:0]  o_s40 [3];
	logic signed [PSW-1:0] ps [3];
	logic signed [CB-1:0]  pc [3];

	logic                 vld_s41, hit_s41, closer_s41;
	logic [TW-1:0]        dist_s41;
	logic signed [CB-1:0] p_s41 [3];
	logic [BW-1:0]        u_s41, v_s41;

	assign d_in[0] = side_i.dx;
	assign d_in[1] = side_i.dy;
	assign d_in[2] = side_i.dz;
	assign o_in[0] = side_i.ox;
	assign o_in[1] = side_i.oy;
	assign o_in[2] = side_i.oz;

	assign range_ok = (t_i >= t_min) && (t_i <= t_max) && !((t_i == t_max) && inexact_i);
	assign tri_hit  = !flg_i.det_zero && !flg_i.tn_neg && !flg_i.far && range_ok
		&& flg_i.tri_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s40 <= 1'b0;
			vld_s41 <= 1'b0;
		end else if (en) begin
			vld_s40 <= vld_i;
			vld_s41 <= vld_s40;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_axis
		always_comb begin
			ps[g] = PSW'(o_s40[g]) + PSW'(pt_s40[g] >>> FRAC);
			if (ps[g] > PMAX) begin
				pc[g] = CB'(PMAX);
			end else if (ps[g] < PMIN) begin
				pc[g] = CB'(PMIN);
			end else begin
				pc[g] = CB'(ps[g]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pt_s40[g] <= PTW'($signed({1'b0, t_i})) * PTW'(d_in[g]);
				o_s40[g]  <= o_in[g];
				p_s41[g]  <= closer_s40 ? pc[g] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s40    <= flg_i.par ? flg_i.par_hit : tri_hit;
			closer_s40 <= !flg_i.par && tri_hit && (side_i.best > t_i);
			t_s40      <= t_i;
			best_s40   <= side_i.best;
			u_s40      <= u_i;
			v_s40      <= v_i;

			hit_s41    <= hit_s40;
			closer_s41 <= closer_s40;
			dist_s41   <= closer_s40 ? t_s40 : best_s40;
			u_s41      <= closer_s40 ? u_s40 : '0;
			v_s41      <= closer_s40 ? v_s40 : '0;
		end
	end

	assign vld_o    = vld_s41;
	assign hit      = hit_s41;
	assign closer   = closer_s41;
	assign new_dist = dist_s41;
	assign point_x  = p_s41[0];
	assign point_y  = p_s41[1];
	assign point_z  = p_s41[2];
	assign bary_u   = u_s41;
	assign bary_v   = v_s41;

endmodule

[rtl/ray_triangle_intersect_top.sv]
// top level of the ray triangle intersection pipeline with its register file
//
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     origin_x..z, dir_x..z, best_dist
// out       output     out_valid / out_stall   hit, closer, new_dist, point_x..z, bary_u, bary_v
// cfg       input      cfg_wr_en               cfg_index, cfg_data
//
// one transaction per cycle while the output is not stalled; each ray passes to the output register through
// 7 geometry stages, 32 divider stages (one quotient bit of t per stage) and 2 result stages
// reset clears all valid bits and loads the register defaults
// a stalled output freezes the whole pipeline and in_stall follows it
module ray_triangle_intersect_top import rti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [CB-1:0] origin_x,
	input  logic signed [CB-1:0] origin_y,
	input  logic signed [CB-1:0] origin_z,
	input  logic signed [CB-1:0] dir_x,
	input  logic signed [CB-1:0] dir_y,
	input  logic signed [CB-1:0] dir_z,
	input  logic [TW-1:0]        best_dist,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic                 closer,
	output logic [TW-1:0]        new_dist,
	output logic signed [CB-1:0] point_x,
	output logic signed [CB-1:0] point_y,
	output logic signed [CB-1:0] point_z,
	output logic [BW-1:0]        bary_u,
	output logic [BW-1:0]        bary_v,
	input  logic                 cfg_wr_en,
	input  logic [CIW-1:0]       cfg_index,
	input  logic [VW-1:0]        cfg_data
);

	logic [VW-1:0] va_q, vb_q, vc_q;
	logic [TW-1:0] t_min_q, t_max_q;
	logic en;
	side_t side_in;

	logic                 f_vld;
	side_t                f_side;
	flags_t               f_flg;
	logic signed [DW-1:0] f_det, f_tn, f_un, f_vn;

	logic            d_vld;
	side_t           d_side;
	flags_t          d_flg;
	logic [TW-1:0]   d_t;
	logic            d_inexact;
	logic [BW-1:0]   d_u, d_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q    <= '0;
			vb_q    <= '0;
			vc_q    <= '0;
			t_min_q <= TW'(1);
			t_max_q <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_VERTEX_A: va_q    <= cfg_data;
				REG_VERTEX_B: vb_q    <= cfg_data;
				REG_VERTEX_C: vc_q    <= cfg_data;
				REG_T_MIN:    t_min_q <= cfg_data[TW-1:0];
				REG_T_MAX:    t_max_q <= cfg_data[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign side_in.ox   = origin_x;
	assign side_in.oy   = origin_y;
	assign side_in.oz   = origin_z;
	assign side_in.dx   = dir_x;
	assign side_in.dy   = dir_y;
	assign side_in.dz   = dir_z;
	assign side_in.best = best_dist;

	rti_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (in_valid),
		.side_i (side_in),
		.va     (va_q),
		.vb     (vb_q),
		.vc     (vc_q),
		.vld_o  (f_vld),
		.side_o (f_side),
		.flg_o  (f_flg),
		.det_o  (f_det),
		.tn_o   (f_tn),
		.un_o   (f_un),
		.vn_o   (f_vn)
	);

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (f_vld),
		.side_i    (f_side),
		.flg_i     (f_flg),
		.det_i     (f_det),
		.tn_i      (f_tn),
		.un_i      (f_un),
		.vn_i      (f_vn),
		.vld_o     (d_vld),
		.side_o    (d_side),
		.flg_o     (d_flg),
		.t_o       (d_t),
		.inexact_o (d_inexact),
		.u_o       (d_u),
		.v_o       (d_v)
	);

	rti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (d_vld),
		.side_i    (d_side),
		.flg_i     (d_flg),
		.t_i       (d_t),
		.inexact_i (d_inexact),
		.u_i       (d_u),
		.v_i       (d_v),
		.t_min     (t_min_q),
		.t_max     (t_max_q),
		.vld_o     (out_valid),
		.hit       (hit),
		.closer    (closer),
		.new_dist  (new_dist),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.bary_u    (bary_u),
		.bary_v    (bary_v)
	);

endmodule
